### hdl/fqd_pkg.sv
package fqd_pkg;

	// width of the value field on both channels
	localparam int VALUE_BITS = 32;

	// request kinds
	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_DELETE  = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// request broadcast from the top level to every cell
	typedef struct packed {
		logic                  accept;
		cmd_t                  cmd;
		logic [VALUE_BITS-1:0] value;
	} fqd_req_t;

endpackage

### hdl/fqd_cell.sv
module fqd_cell #(
	parameter int W = 32
) (
	input  logic             clk,
	input  fqd_pkg::fqd_req_t req,
	input  logic             live,       // this cell holds a stored entry
	input  logic             at_tail,    // this cell is the first free slot
	input  logic             seen_in,    // a match exists in an older cell
	output logic             seen_out,
	input  logic [W-1:0]     next_value, // entry of the next younger cell
	output logic [W-1:0]     cur_value
);
	import fqd_pkg::*;

	logic [W-1:0] entry_q;
	logic         hit;
	logic         shift;
	logic         load;

	// match on delete, passed down the chain as a prefix or
	assign hit      = live && (req.cmd == CMD_DELETE) && (entry_q == req.value[W-1:0]);
	assign seen_out = seen_in | hit;

	// take the neighbor's entry on dequeue or at and behind the deleted slot
	assign shift = req.accept && live &&
		((req.cmd == CMD_DEQUEUE) || ((req.cmd == CMD_DELETE) && seen_out));
	assign load  = req.accept && at_tail && (req.cmd == CMD_ENQUEUE);

	// entry storage
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= next_value;
		end else if (load) begin
			entry_q <= req.value[W-1:0];
		end
	end

	assign cur_value = entry_q;

endmodule

### hdl/fifo_queue_with_delete.sv
// Bounded first-in first-out queue of values with delete by value.
// Requests arrive on the s_ channel: s_tdata holds command in bits [1:0]
// (enqueue, dequeue, delete) and value in bits [33:2]. Every request gives
// exactly one result on the m_ channel: status, dequeued value (zero unless a
// dequeue succeeds) and the number of stored entries after the request.
// The entries sit in a row of DEPTH cells, oldest in cell 0. Each cell compares
// its entry with the delete value in parallel; a ripple of match flags down
// the row marks the oldest match, and that cell and all younger ones take their
// neighbor's entry in the same cycle. Dequeue shifts every live cell.
// The result is registered and appears in the cycle after the request; one request per cycle is taken
// as long as the result register is empty or being drained in that cycle.
// When the receiver stalls, the result is held and s_tready drops until it is
// taken. Reset empties the queue and clears the result valid flag, not the payload;
// entry contents are left as they are and are never read before being written.
module fifo_queue_with_delete #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [39:0] s_tdata, // command[1:0], value[33:2], zero fill
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((fqd_pkg::VALUE_BITS + 2 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
		m_tdata // status[1:0], data_out[33:2], length above, zero fill
);
	import fqd_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SW    = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
	localparam int M_W   = ((VALUE_BITS + 2 + CNT_W + 7) / 8) * 8;

	fqd_req_t         req;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             accept;
	logic             found;
	status_t          status;
	logic [VALUE_BITS-1:0] data;

	logic [DEPTH:0]   seen;
	logic [SW-1:0]    cell_value [DEPTH];

	status_t               out_status_q;
	logic [VALUE_BITS-1:0] out_data_q;
	logic [CNT_W-1:0]      out_len_q;
	logic                  out_valid_q;

	// request handshake
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign req.accept = accept;
	assign req.cmd    = cmd_t'(s_tdata[1:0]);
	assign req.value  = s_tdata[VALUE_BITS+1:2];

	// row of cells
	assign seen[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [SW-1:0] nv;
		if (i == DEPTH - 1) begin : g_last
			assign nv = cell_value[i];
		end else begin : g_mid
			assign nv = cell_value[i+1];
		end
		fqd_cell #(.W(SW)) u_cell (
			.clk       (clk),
			.req       (req),
			.live      (CNT_W'(i) < count_q),
			.at_tail   (CNT_W'(i) == count_q),
			.seen_in   (seen[i]),
			.seen_out  (seen[i+1]),
			.next_value(nv),
			.cur_value (cell_value[i])
		);
	end
	assign found = seen[DEPTH];

	// result and next length
	always_comb begin
		status    = ST_OK;
		data      = '0;
		count_nxt = count_q;
		case (req.cmd)
			CMD_ENQUEUE: begin
				if (count_q == CNT_W'(DEPTH)) begin
					status = ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_DEQUEUE: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					data      = VALUE_BITS'(cell_value[0]);
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_DELETE: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (!found) begin
					status = ST_NOTFOUND;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status;
			out_data_q   <= data;
			out_len_q    <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_W'({out_len_q, out_data_q, out_status_q});

	// length never exceeds the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue length above depth");

	// a successful enqueue grows the queue by one
	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == CMD_ENQUEUE) && (count_q != CNT_W'(DEPTH)))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("enqueue did not grow the queue");

	// a delete that finds its value shrinks the queue by one
	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == CMD_DELETE) && (count_q != '0) && found)
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("delete did not shrink the queue");

	// an empty status is only reported with zero length
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_EMPTY)) |-> (out_len_q == '0))
		else $error("empty status with nonzero length");

	// a stalled result does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_len_q)
		&& $stable(out_data_q)))
		else $error("result changed while stalled");

endmodule
